FILE: hw/rtl/weighted_premult_color_error_core_defines.svh
// Assertion macros for the weighted premultiplied color error core.
// Expects clk and rst_n in the scope of each use.
`ifndef WEIGHTED_PREMULT_COLOR_ERROR_CORE_DEFINES_SVH
`define WEIGHTED_PREMULT_COLOR_ERROR_CORE_DEFINES_SVH

// same-cycle implication
`define WPCE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpce: same-cycle check failed");

// next-cycle implication
`define WPCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpce: next-cycle check failed");

`endif

FILE: hw/rtl/wpce_pkg.sv
// Shared types, codes, weights and premultiply helper for the color error core.
// No dependencies.
`timescale 1ns / 1ps

package wpce_pkg;

    localparam int WFB   = 16;
    localparam int W_W   = WFB + 1;
    localparam int E_W   = 8 + W_W;
    localparam int SQ_W  = 2 * E_W;
    localparam int SUM_W = 50;
    localparam int LANES = 4;
    localparam int SQ_DOWN = (2 * WFB > 32) ? (2 * WFB - 32) : 0;
    localparam int SQ_UP   = (2 * WFB < 32) ? (32 - 2 * WFB) : 0;

    localparam logic [W_W-1:0] W_UNIT   = W_W'(64'd1 << WFB);
    localparam logic [W_W-1:0] W_LUMA_R = W_W'(((64'd299 << WFB) + 64'd500) / 64'd1000);
    localparam logic [W_W-1:0] W_LUMA_G = W_W'(((64'd587 << WFB) + 64'd500) / 64'd1000);
    localparam logic [W_W-1:0] W_LUMA_B = W_W'(((64'd114 << WFB) + 64'd500) / 64'd1000);
    localparam logic [W_W-1:0] W_ALT_R  = W_W'(((64'd3086 << WFB) + 64'd5000) / 64'd10000);
    localparam logic [W_W-1:0] W_ALT_G  = W_W'(((64'd6094 << WFB) + 64'd5000) / 64'd10000);
    localparam logic [W_W-1:0] W_ALT_B  = W_W'(((64'd820 << WFB) + 64'd5000) / 64'd10000);

    localparam logic [1:0] WM_UNIFORM = 2'd0;
    localparam logic [1:0] WM_LUMA    = 2'd1;
    localparam logic [1:0] WM_ALT     = 2'd2;

    localparam logic [2:0] FN_FOUR      = 3'd0;
    localparam logic [2:0] FN_THREE     = 3'd1;
    localparam logic [2:0] FN_ONE       = 3'd2;
    localparam logic [2:0] FN_FOUR_PM   = 3'd3;
    localparam logic [2:0] FN_THREE_AOUT = 3'd4;
    localparam logic [2:0] FN_THREE_AIN = 3'd5;
    localparam logic [2:0] FN_ONE_PM    = 3'd6;
    localparam logic [2:0] FN_UNDEF     = 3'd7;

    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_R    = 2'd1;
    localparam logic [1:0] ROT_G    = 2'd2;
    localparam logic [1:0] ROT_B    = 2'd3;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int CH_A = 3;

    typedef struct packed {
        logic [2:0] func;
        logic [1:0] rotate_mode;
        logic [7:0] first_red;
        logic [7:0] first_green;
        logic [7:0] first_blue;
        logic [7:0] first_alpha;
        logic [7:0] second_red;
        logic [7:0] second_green;
        logic [7:0] second_blue;
        logic [7:0] second_alpha;
    } in_word_t;

    typedef struct packed {
        logic [SUM_W-1:0] error_sum;
        logic             bad_request;
    } out_word_t;

    typedef struct packed {
        logic [7:0]     x;
        logic [7:0]     y;
        logic [W_W-1:0] w;
    } lane_op_t;

    // (x*a + 127) / 255, exact for 8-bit operands
    function automatic logic [7:0] pm(input logic [7:0] x, input logic [7:0] a);
        logic [16:0] v;
        logic [16:0] t;
        v = 17'(x) * 17'(a) + 17'd127;
        t = v + (v >> 8) + 17'd1;
        return t[15:8];
    endfunction

endpackage

FILE: hw/rtl/wpce_prep.sv
// Front stage: metric decode, premultiply and per-lane operand/weight selection.
// Depends on wpce_pkg.
`timescale 1ns / 1ps

module wpce_prep (
    input  logic                                 clk,
    input  logic                                 en,
    input  wpce_pkg::in_word_t                   pixel,
    input  logic [1:0]                           weight_mode,
    output wpce_pkg::lane_op_t [wpce_pkg::LANES-1:0] ops,
    output logic                                 bad
);
    import wpce_pkg::*;

    lane_op_t [LANES-1:0] ops_next, ops_reg;
    logic                 bad_next, bad_reg;
    logic [7:0]           c0 [LANES];
    logic [7:0]           c1 [LANES];
    logic [7:0]           p0 [3];
    logic [7:0]           p1 [3];
    logic [W_W-1:0]       wt [3];
    logic [W_W-1:0]       w1;
    logic [7:0]           f0, f1;
    logic [1:0]           ai;
    logic                 rot_on;

    always_comb
    begin
        c0 = '{pixel.first_red, pixel.first_green, pixel.first_blue, pixel.first_alpha};
        c1 = '{pixel.second_red, pixel.second_green, pixel.second_blue, pixel.second_alpha};
        ai = pixel.rotate_mode - 2'd1;
        rot_on = (pixel.rotate_mode != ROT_NONE);

        f0 = (pixel.func == FN_THREE_AIN) ? c0[ai] : c0[CH_A];
        f1 = (pixel.func == FN_THREE_AIN) ? c1[ai] : c1[CH_A];
        for (int i = 0; i < 3; i++)
        begin
            p0[i] = pm(c0[i], f0);
            p1[i] = pm(c1[i], f1);
        end

        unique case (weight_mode)
            WM_LUMA:
            begin
                wt = '{W_LUMA_R, W_LUMA_G, W_LUMA_B};
            end
            WM_ALT:
            begin
                wt = '{W_ALT_R, W_ALT_G, W_ALT_B};
            end
            default:
            begin
                wt = '{W_UNIT, W_UNIT, W_UNIT};
            end
        endcase

        unique case (pixel.rotate_mode)
            ROT_R:   w1 = wt[CH_R];
            ROT_G:   w1 = wt[CH_G];
            ROT_B:   w1 = wt[CH_B];
            default: w1 = W_UNIT;
        endcase

        bad_next = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            ops_next[i].x = c0[i];
            ops_next[i].y = c1[i];
            ops_next[i].w = '0;
        end

        unique case (pixel.func)
            FN_FOUR:
            begin
                for (int i = 0; i < 3; i++)
                    ops_next[i].w = wt[i];
                ops_next[CH_A].w = W_UNIT;
            end
            FN_THREE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ops_next[i].w = wt[i];
                    if ((weight_mode == WM_LUMA || weight_mode == WM_ALT) && rot_on
                        && ai == 2'(i))
                        ops_next[i].w = W_UNIT;
                end
            end
            FN_ONE:
            begin
                ops_next[CH_R].w = w1;
            end
            FN_FOUR_PM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ops_next[i].x = p0[i];
                    ops_next[i].y = p1[i];
                    ops_next[i].w = wt[i];
                end
                ops_next[CH_A].w = W_UNIT;
            end
            FN_THREE_AOUT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ops_next[i].x = p0[i];
                    ops_next[i].y = p1[i];
                    ops_next[i].w = wt[i];
                end
            end
            FN_THREE_AIN:
            begin
                if (!rot_on)
                    bad_next = 1'b1;
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (ai != 2'(i))
                        begin
                            ops_next[i].x = p0[i];
                            ops_next[i].y = p1[i];
                        end
                        ops_next[i].w = wt[i];
                    end
                end
            end
            FN_ONE_PM:
            begin
                ops_next[CH_R].x = p0[CH_R];
                ops_next[CH_R].y = p1[CH_R];
                ops_next[CH_R].w = w1;
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ops_reg <= ops_next;
            bad_reg <= bad_next;
        end
    end

    assign ops = ops_reg;
    assign bad = bad_reg;

endmodule

FILE: hw/rtl/wpce_lane.sv
// One channel lane: absolute difference times weight, then square.
// Two register stages; depends on wpce_pkg.
`timescale 1ns / 1ps

module wpce_lane (
    input  logic                          clk,
    input  logic                          en,
    input  wpce_pkg::lane_op_t            op,
    output logic [wpce_pkg::SUM_W-1:0]    term
);
    import wpce_pkg::*;

    logic [7:0]      d;
    logic [E_W-1:0]  e_next, e_reg;
    logic [SQ_W-1:0] sq_next, sq_reg;

    always_comb
    begin
        d       = (op.x > op.y) ? (op.x - op.y) : (op.y - op.x);
        e_next  = E_W'(d) * E_W'(op.w);
        sq_next = SQ_W'(e_reg) * SQ_W'(e_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg  <= e_next;
            sq_reg <= sq_next;
        end
    end

    assign term = SUM_W'(SUM_W'(sq_reg >> SQ_DOWN) << SQ_UP);

endmodule

FILE: hw/rtl/wpce_merge.sv
// Merge stage: sums the lane terms into the output word register.
// Depends on wpce_pkg.
`timescale 1ns / 1ps

module wpce_merge (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic [wpce_pkg::LANES-1:0][wpce_pkg::SUM_W-1:0] terms,
    input  logic                                     bad,
    output wpce_pkg::out_word_t                      result
);
    import wpce_pkg::*;

    out_word_t result_next, result_reg;

    always_comb
    begin
        result_next.error_sum = '0;
        for (int i = 0; i < LANES; i++)
            result_next.error_sum = result_next.error_sum + terms[i];
        result_next.bad_request = bad;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

FILE: hw/rtl/weighted_premult_color_error_core.sv
// Weighted (optionally premultiplied) squared color error, four-lane pipeline.
// Depends on wpce_pkg, wpce_prep, wpce_lane, wpce_merge and the defines header.
//
// Takes one pixel-pair word per clock unless stalled; each yields one result.
// The four stages are operand select and premultiply, difference times
// weight, square, and the lane sum; R, G, B and A each run in their own lane.
// A stalled result holds the whole pipeline, so pixel_ready is low only while
// a finished result waits. cfg_ready is always high; write weight_mode only
// while no words are in flight.
`timescale 1ns / 1ps
`include "weighted_premult_color_error_core_defines.svh"

module weighted_premult_color_error_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  wpce_pkg::in_word_t   pixel,
    output logic                 result_valid,
    input  logic                 result_ready,
    output wpce_pkg::out_word_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data
);
    import wpce_pkg::*;

    logic [3:0]                      v_reg, v_next;
    logic [1:0]                      weight_mode_reg;
    logic                            advance;
    logic                            bad_a, bad_b_reg, bad_c_reg;
    lane_op_t [LANES-1:0]            ops;
    logic [LANES-1:0][SUM_W-1:0]     terms;

    assign advance      = !v_reg[3] || result_ready;
    assign pixel_ready  = advance;
    assign result_valid = v_reg[3];
    assign cfg_ready    = 1'b1;
    assign v_next       = {v_reg[2:0], pixel_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg           <= '0;
            weight_mode_reg <= WM_UNIFORM;
        end
        else
        begin
            if (advance)
                v_reg <= v_next;
            if (cfg_valid && cfg_ready)
                weight_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bad_b_reg <= bad_a;
            bad_c_reg <= bad_b_reg;
        end
    end

    wpce_prep u_prep (
        .clk         (clk),
        .en          (advance),
        .pixel       (pixel),
        .weight_mode (weight_mode_reg),
        .ops         (ops),
        .bad         (bad_a)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        wpce_lane u_lane (
            .clk  (clk),
            .en   (advance),
            .op   (ops[g]),
            .term (terms[g])
        );
    end

    wpce_merge u_merge (
        .clk    (clk),
        .en     (advance),
        .terms  (terms),
        .bad    (bad_c_reg),
        .result (result)
    );

    `WPCE_ASSERT_IMPLY(a_bad_zero, result_valid && result.bad_request, result.error_sum == '0)
    `WPCE_ASSERT_NEXT(a_stall_hold, !advance, v_reg == $past(v_reg))
    `WPCE_ASSERT_NEXT(a_undef_flag, pixel_valid && pixel_ready && pixel.func == FN_UNDEF, bad_a)
    `WPCE_ASSERT_NEXT(a_fill, pixel_valid && pixel_ready, v_reg[0])

endmodule
